### hw/rtl/smpq_pkg.sv
// Shared types and codes for the stable minimum priority queue.
// Depends on nothing; used by smpq_cell and stable_min_priority_queue_top.
package smpq_pkg;

   localparam int DefaultQueueDepth = 64;

   localparam logic [1:0] FUNC_INSERT = 2'd0;
   localparam logic [1:0] FUNC_POP    = 2'd1;
   localparam logic [1:0] FUNC_CLEAR  = 2'd2;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_EMPTY    = 2'd1;
   localparam logic [1:0] ST_BADPAGES = 2'd2;
   localparam logic [1:0] ST_FULL     = 2'd3;

   typedef struct packed {
      logic [1:0]  func;
      logic [15:0] pages;
      logic [15:0] job_tag;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] out_tag;
      logic [15:0] out_pages;
      logic [6:0]  occupancy;
   } rsp_type;

   typedef struct packed {
      logic [15:0] pages;
      logic [15:0] tag;
   } entry_type;

   // broadcast to every cell of the chain
   typedef struct packed {
      logic      ins;
      logic      pop;
      entry_type new_entry;
   } cell_ctrl_type;

endpackage

### hw/rtl/smpq_cell.sv
// One slot of the sorted chain: holds an entry and shifts with its neighbors.
// Depends on smpq_pkg.
module smpq_cell (
   input  logic                   clock,
   input  smpq_pkg::cell_ctrl_type ctrl,
   input  logic                   held,
   input  logic                   prev_keep,
   input  smpq_pkg::entry_type    prev_entry,
   input  smpq_pkg::entry_type    next_entry,
   output logic                   keep,
   output smpq_pkg::entry_type    entry
);
   import smpq_pkg::*;

   entry_type entry_ff, entry_in;

   // a held entry with the same or fewer pages stays ahead of the new job
   assign keep  = held && (entry_ff.pages <= ctrl.new_entry.pages);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.pop) begin
         entry_in = next_entry;
      end else if (ctrl.ins && !keep) begin
         entry_in = prev_keep ? ctrl.new_entry : prev_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

### hw/rtl/stable_min_priority_queue_top.sv
// Stable minimum priority queue: a shortest-job-first queue of tagged jobs.
// Insert, pop and clear each update the queue when they are accepted, because
// a row of QUEUE_DEPTH cells compares the new page count against every held
// entry at once and shifts in a single step. Jobs with equal page counts leave
// in arrival order. The result beat sits in an output register, so a new
// request is taken while no result is waiting or the waiting one is being
// taken. Depends on smpq_pkg and smpq_cell.
module stable_min_priority_queue_top #(
   parameter int QUEUE_DEPTH = smpq_pkg::DefaultQueueDepth
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  smpq_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output smpq_pkg::rsp_type rsp_data
);
   import smpq_pkg::*;

   localparam int CntW = $clog2(QUEUE_DEPTH + 1);

   logic [CntW-1:0] count_ff, count_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_ff, rsp_in;

   logic            accept;
   cell_ctrl_type   ctrl;
   logic            held [QUEUE_DEPTH];
   logic            keep [QUEUE_DEPTH];
   entry_type       entry [QUEUE_DEPTH];

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      ctrl.ins             = 1'b0;
      ctrl.pop             = 1'b0;
      ctrl.new_entry.pages = req_data.pages;
      ctrl.new_entry.tag   = req_data.job_tag;
      count_in             = count_ff;
      rsp_in.status        = ST_OK;
      rsp_in.out_tag       = '0;
      rsp_in.out_pages     = '0;
      case (req_data.func)
         FUNC_INSERT: begin
            if (req_data.pages == '0) begin
               rsp_in.status = ST_BADPAGES;
            end else if (count_ff >= CntW'(QUEUE_DEPTH)) begin
               rsp_in.status = ST_FULL;
            end else begin
               ctrl.ins = accept;
               count_in = count_ff + 1'b1;
            end
         end
         FUNC_POP: begin
            if (count_ff == '0) begin
               rsp_in.status = ST_EMPTY;
            end else begin
               ctrl.pop         = accept;
               count_in         = count_ff - 1'b1;
               rsp_in.out_tag   = entry[0].tag;
               rsp_in.out_pages = entry[0].pages;
            end
         end
         FUNC_CLEAR: begin
            if (count_ff == '0) begin
               rsp_in.status = ST_EMPTY;
            end else begin
               count_in = '0;
            end
         end
         default: begin
         end
      endcase
      rsp_in.occupancy = 7'(count_in);
      if (!accept) begin
         count_in = count_ff;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   genvar i;
   generate
      for (i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
         assign held[i] = (CntW'(i) < count_ff);
         smpq_cell u_cell (
            .clock      (clock),
            .ctrl       (ctrl),
            .held       (held[i]),
            .prev_keep  ((i == 0) ? 1'b1 : keep[(i == 0) ? 0 : i - 1]),
            .prev_entry (entry[(i == 0) ? 0 : i - 1]),
            .next_entry (entry[(i == QUEUE_DEPTH - 1) ? i : i + 1]),
            .keep       (keep[i]),
            .entry      (entry[i])
         );
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold the result while it waits
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule
